// File: src/psfd_pkg.sv
// psfd_pkg: request/result types, control bundles and constants of the flood detector
// used by every module of the block; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package psfd_pkg;

    localparam int ADDR_W  = 32;
    localparam int REG_W   = 24;
    localparam int RISK_W  = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [RISK_W-1:0] RISK_LOW    = 2'd0;
    localparam logic [RISK_W-1:0] RISK_MEDIUM = 2'd1;
    localparam logic [RISK_W-1:0] RISK_HIGH   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ALERT_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_LEVEL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_LEVEL      = 2'd2;

    localparam logic [REG_W-1:0] ALERT_THRESHOLD_RST = 24'd100;
    localparam logic [REG_W-1:0] MEDIUM_LEVEL_RST    = 24'd200;
    localparam logic [REG_W-1:0] HIGH_LEVEL_RST      = 24'd500;

    localparam logic MODE_PACKET     = 1'b0;
    localparam logic MODE_WINDOW_END = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] source_address;
    } t_req;

    typedef struct packed {
        logic              alert_valid;
        logic [ADDR_W-1:0] alert_address;
        logic [REG_W-1:0]  alert_count;
        logic [RISK_W-1:0] risk_level;
        logic              table_overflow;
        logic              last;
    } t_rsp;

    typedef struct packed {
        logic compare;
        logic apply;
        logic no_hit;
        logic shift;
    } t_cell_ctrl;

    typedef struct packed {
        logic step;
        logic flush;
        logic overflow;
    } t_rpt_ctrl;

endpackage
`default_nettype wire

// File: src/psfd_cell.sv
// psfd_cell: one table entry (used flag, source address, packet count)
// depends on psfd_pkg; shifts toward the head of the row during the window-end scan
`timescale 1ns / 1ps
`default_nettype none
module psfd_cell
    import psfd_pkg::*;
#(
    parameter int COUNT_BITS = 24
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cell_ctrl            i_ctrl,
    input  wire logic [ADDR_W-1:0]     i_addr,
    input  wire logic                  i_prev_used,
    input  wire logic                  i_next_used,
    input  wire logic [ADDR_W-1:0]     i_next_addr,
    input  wire logic [COUNT_BITS-1:0] i_next_count,
    output logic                       o_used,
    output logic [ADDR_W-1:0]          o_addr,
    output logic [COUNT_BITS-1:0]      o_count,
    output logic                       o_match
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    logic                  r_used, n_used;
    logic [ADDR_W-1:0]     r_addr, n_addr;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic                  r_match, n_match;

    always_comb begin
        n_used  = r_used;
        n_addr  = r_addr;
        n_count = r_count;
        n_match = r_match;
        if (i_ctrl.compare) begin
            n_match = r_used && (r_addr == i_addr);
        end
        if (i_ctrl.shift) begin
            n_used  = i_next_used;
            n_addr  = i_next_addr;
            n_count = i_next_count;
        end else if (i_ctrl.apply) begin
            if (r_match && (r_count != COUNT_MAX)) begin
                n_count = r_count + COUNT_ONE;
            end
            if (i_ctrl.no_hit && !r_used && i_prev_used) begin
                n_used  = 1'b1;
                n_addr  = i_addr;
                n_count = COUNT_ONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= 1'b0;
            r_match <= 1'b0;
        end else begin
            r_used  <= n_used;
            r_match <= n_match;
        end
        r_addr  <= n_addr;
        r_count <= n_count;
    end

    assign o_used  = r_used;
    assign o_addr  = r_addr;
    assign o_count = r_count;
    assign o_match = r_match;

endmodule
`default_nettype wire

// File: src/psfd_report.sv
// psfd_report: checks the head cell against the thresholds and builds the result stream
// depends on psfd_pkg; holds one pending alert so the final one can carry last
`timescale 1ns / 1ps
`default_nettype none
module psfd_report
    import psfd_pkg::*;
#(
    parameter int COUNT_BITS = 24
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_rpt_ctrl             i_ctrl,
    input  wire logic                  i_head_used,
    input  wire logic [ADDR_W-1:0]     i_head_addr,
    input  wire logic [COUNT_BITS-1:0] i_head_count,
    input  wire logic [REG_W-1:0]      i_threshold,
    input  wire logic [REG_W-1:0]      i_medium,
    input  wire logic [REG_W-1:0]      i_high,
    output logic                       o_valid,
    output t_rsp                       o_rsp
);

    localparam int CMP_W = (COUNT_BITS > REG_W) ? COUNT_BITS : REG_W;

    logic [CMP_W-1:0]  head_count;
    logic              hit;
    logic [RISK_W-1:0] risk;

    logic              r_pend_v, n_pend_v;
    logic [ADDR_W-1:0] r_pend_addr, n_pend_addr;
    logic [REG_W-1:0]  r_pend_count, n_pend_count;
    logic [RISK_W-1:0] r_pend_risk, n_pend_risk;
    logic              r_valid, n_valid;
    t_rsp              r_rsp, n_rsp;

    assign head_count = CMP_W'(i_head_count);
    assign hit = i_ctrl.step && i_head_used && (head_count > CMP_W'(i_threshold));

    always_comb begin
        if (head_count > CMP_W'(i_high)) begin
            risk = RISK_HIGH;
        end else if (head_count > CMP_W'(i_medium)) begin
            risk = RISK_MEDIUM;
        end else begin
            risk = RISK_LOW;
        end
    end

    always_comb begin
        n_pend_v     = r_pend_v;
        n_pend_addr  = r_pend_addr;
        n_pend_count = r_pend_count;
        n_pend_risk  = r_pend_risk;
        n_valid      = 1'b0;
        n_rsp        = '0;
        if (hit) begin
            if (r_pend_v) begin
                n_valid             = 1'b1;
                n_rsp.alert_valid   = 1'b1;
                n_rsp.alert_address = r_pend_addr;
                n_rsp.alert_count   = r_pend_count;
                n_rsp.risk_level    = r_pend_risk;
            end
            n_pend_v     = 1'b1;
            n_pend_addr  = i_head_addr;
            n_pend_count = head_count[REG_W-1:0];
            n_pend_risk  = risk;
        end else if (i_ctrl.flush) begin
            n_valid    = 1'b1;
            n_rsp.last = 1'b1;
            if (r_pend_v) begin
                n_rsp.alert_valid   = 1'b1;
                n_rsp.alert_address = r_pend_addr;
                n_rsp.alert_count   = r_pend_count;
                n_rsp.risk_level    = r_pend_risk;
            end
            n_pend_v = 1'b0;
        end else if (i_ctrl.overflow) begin
            n_valid              = 1'b1;
            n_rsp.table_overflow = 1'b1;
            n_rsp.last           = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_pend_v <= n_pend_v;
            r_valid  <= n_valid;
        end
        r_pend_addr  <= n_pend_addr;
        r_pend_count <= n_pend_count;
        r_pend_risk  <= n_pend_risk;
        r_rsp        <= n_rsp;
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule
`default_nettype wire

// File: src/per_source_flood_detector.sv
// per_source_flood_detector: top level, row of table cells, sequencer and result stage
// depends on psfd_pkg, psfd_cell and psfd_report
// packet request: busy in the LOOK state after accept; an overflow result is decided in LOOK
//   and registered in the result stage before it strobes. window-end request: busy in SCAN and FLUSH while
//   the row shifts out through the head cell, one entry a cycle; results strobe one at a time,
//   the final one, marked last, comes from the FLUSH state. results cannot be stalled by the receiver.
// synchronous active-low reset clears the table, returns thresholds to 100/200/500.
`timescale 1ns / 1ps
`default_nettype none
module per_source_flood_detector
    import psfd_pkg::*;
#(
    parameter int TABLE_ENTRIES = 32,
    parameter int COUNT_BITS    = 24
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire t_req                 i_req,
    output logic                      o_busy,
    output logic                      o_strobe,
    output t_rsp                      o_rsp,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [REG_W-1:0]     i_cfg_data
);

    localparam int CNT_W = $clog2(TABLE_ENTRIES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_ENTRIES - 1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LOOK  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [ADDR_W-1:0] r_addr;
    logic [REG_W-1:0]  r_threshold, r_medium, r_high;

    logic accept;
    logic any_hit;
    logic full;
    logic [ADDR_W-1:0] bus_addr;
    t_cell_ctrl cell_ctrl;
    t_rpt_ctrl  rpt_ctrl;

    logic [TABLE_ENTRIES:0]  used;
    logic [ADDR_W-1:0]       addr  [TABLE_ENTRIES+1];
    logic [COUNT_BITS-1:0]   count [TABLE_ENTRIES+1];
    logic [TABLE_ENTRIES-1:0] match;

    assign accept   = i_start && (r_state == ST_IDLE);
    assign o_busy   = (r_state != ST_IDLE);
    assign any_hit  = |match;
    assign full     = used[TABLE_ENTRIES-1];
    assign bus_addr = (r_state == ST_LOOK) ? r_addr : i_req.source_address;

    assign cell_ctrl.compare = accept && (i_req.mode == MODE_PACKET);
    assign cell_ctrl.apply   = (r_state == ST_LOOK);
    assign cell_ctrl.no_hit  = !any_hit;
    assign cell_ctrl.shift   = (r_state == ST_SCAN);

    assign rpt_ctrl.step     = (r_state == ST_SCAN);
    assign rpt_ctrl.flush    = (r_state == ST_FLUSH);
    assign rpt_ctrl.overflow = (r_state == ST_LOOK) && !any_hit && full;

    // empty entry shifted in behind the last cell
    assign used[TABLE_ENTRIES]  = 1'b0;
    assign addr[TABLE_ENTRIES]  = '0;
    assign count[TABLE_ENTRIES] = '0;

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
            logic prev_used;
            if (g == 0) begin : g_head
                assign prev_used = 1'b1;
            end else begin : g_body
                assign prev_used = used[g-1];
            end
            psfd_cell #(
                .COUNT_BITS(COUNT_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (cell_ctrl),
                .i_addr       (bus_addr),
                .i_prev_used  (prev_used),
                .i_next_used  (used[g+1]),
                .i_next_addr  (addr[g+1]),
                .i_next_count (count[g+1]),
                .o_used       (used[g]),
                .o_addr       (addr[g]),
                .o_count      (count[g]),
                .o_match      (match[g])
            );
        end
    endgenerate

    psfd_report #(
        .COUNT_BITS(COUNT_BITS)
    ) u_report (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (rpt_ctrl),
        .i_head_used  (used[0]),
        .i_head_addr  (addr[0]),
        .i_head_count (count[0]),
        .i_threshold  (r_threshold),
        .i_medium     (r_medium),
        .i_high       (r_high),
        .o_valid      (o_strobe),
        .o_rsp        (o_rsp)
    );

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_cnt = '0;
                    if (i_req.mode == MODE_WINDOW_END) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_LOOK;
                    end
                end
            end
            ST_LOOK: begin
                n_state = ST_IDLE;
            end
            ST_SCAN: begin
                n_cnt = r_cnt + CNT_ONE;
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_threshold <= ALERT_THRESHOLD_RST;
            r_medium    <= MEDIUM_LEVEL_RST;
            r_high      <= HIGH_LEVEL_RST;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ALERT_THRESHOLD: r_threshold <= i_cfg_data;
                    REG_MEDIUM_LEVEL:    r_medium    <= i_cfg_data;
                    REG_HIGH_LEVEL:      r_high      <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
        if (accept) begin
            r_addr <= i_req.source_address;
        end
    end

endmodule
`default_nettype wire
